// ----- hdl/skvf_pkg.sv -----
// Shared types and codes for the scalar Kalman velocity filter.
// No dependencies; imported by skvf_ctrl, skvf_dp and the top level.
package skvf_pkg;

  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_NOISE    = 2'd0,
    CFG_MEAS_NOISE    = 2'd1,
    CFG_INIT_EST      = 2'd2,
    CFG_INIT_ERR      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_CORR,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // latch measurement
    logic pred;      // prediction, innovation, divider load
    logic div_step;  // one quotient bit
    logic mul_init;  // load gain and (1 - gain) into the multipliers
    logic mul_step;  // one multiplier bit
    logic corr;      // corrected estimate and error
    logic commit;    // update state, load output register
  } dp_cmd_t;

endpackage

// ----- hdl/scalar_kalman_velocity_filter_unit.sv -----
// Top level of the scalar Kalman velocity filter.
// Instantiates skvf_ctrl and skvf_dp; uses skvf_pkg.
//
// One-dimensional Kalman filter with a velocity term in signed fixed point
// (DATA_WIDTH-bit words, FRAC_BITS fraction bits, Q16.16 by default). Each
// measurement transaction yields exactly one result transaction holding the
// corrected estimate, the updated error variance, the velocity (change in
// estimate) and the one-step prediction, all saturated. One transaction is
// in flight at a time. A restoring divider forms the gain one quotient bit
// per cycle; two shift-add multipliers apply it, also one bit per cycle,
// between the prediction and the correction and handoff. A finished result
// sits in an output register; the next measurement is accepted while it
// waits, and the block only stalls at the final step if the previous result
// is still not taken. Config writes (cfg_we, cfg_index, cfg_data) take
// effect at once, reload estimate and error from the initial-value
// registers and clear velocity; issue them only while no transaction is in
// progress. Reset restores defaults of 1.0 for both noise terms and the
// initial error, and 0 for the initial estimate.
module scalar_kalman_velocity_filter_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config port
  input  logic                             cfg_we,
  input  logic [skvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]            cfg_data,
  // measurement channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [DATA_WIDTH-1:0]     in_measurement,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [DATA_WIDTH-1:0]     out_filtered_estimate,
  output logic [DATA_WIDTH-1:0]            out_error_variance,
  output logic signed [DATA_WIDTH-1:0]     out_rate_of_change,
  output logic signed [DATA_WIDTH-1:0]     out_next_prediction
);
  import skvf_pkg::*;

  dp_cmd_t cmd;

  // sequencer: steps one transaction through predict, divide, multiply,
  // correct and commit
  skvf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic, filter state, config registers and output register
  skvf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_measurement        (in_measurement),
    .out_filtered_estimate (out_filtered_estimate),
    .out_error_variance    (out_error_variance),
    .out_rate_of_change    (out_rate_of_change),
    .out_next_prediction   (out_next_prediction)
  );

endmodule

// ----- hdl/skvf_ctrl.sv -----
// Sequencer for the scalar Kalman velocity filter.
// Depends on skvf_pkg; drives skvf_dp through dp_cmd_t.
module skvf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output skvf_pkg::dp_cmd_t cmd
);
  import skvf_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 2);
  localparam logic [CW-1:0] LAST = CW'(FRAC_BITS);

  ctrl_state_t    state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PRED;
      end
      ST_PRED: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == LAST) state_nxt = ST_GAIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_GAIN: begin
        state_nxt = ST_MUL;
        cnt_nxt   = '0;
      end
      ST_MUL: begin
        if (cnt_r == LAST) state_nxt = ST_CORR;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_CORR: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_PRED: cmd.pred     = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_GAIN: cmd.mul_init = 1'b1;
      ST_MUL:  cmd.mul_step = 1'b1;
      ST_CORR: cmd.corr     = 1'b1;
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/skvf_dp.sv -----
// Datapath of the scalar Kalman velocity filter: config registers, state,
// serial divider, two shift-add multipliers, output register. Uses skvf_pkg.
module skvf_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  skvf_pkg::dp_cmd_t                    cmd,
  input  logic                                 cfg_we,
  input  logic [skvf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data,
  input  logic signed [DATA_WIDTH-1:0]         in_measurement,
  output logic signed [DATA_WIDTH-1:0]         out_filtered_estimate,
  output logic [DATA_WIDTH-1:0]                out_error_variance,
  output logic signed [DATA_WIDTH-1:0]         out_rate_of_change,
  output logic signed [DATA_WIDTH-1:0]         out_next_prediction
);
  import skvf_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int GW  = F + 1;       // gain width, 0..1.0
  localparam int RW  = W + 2;       // divider remainder
  localparam int MW  = W + 1;       // innovation magnitude
  localparam int PW1 = MW + GW;
  localparam int PW2 = W + GW;
  localparam logic [W-1:0]  ONE_W = {{(W-1){1'b0}}, 1'b1} << F;
  localparam logic [GW-1:0] ONE_G = {1'b1, {F{1'b0}}};

  function automatic logic [W-1:0] sat3(input logic [W+2:0] x);
    if (x[W+2:W-1] == '0 || x[W+2:W-1] == '1) return x[W-1:0];
    return x[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic [W-1:0] sat1(input logic [W:0] x);
    if (x[W] == x[W-1]) return x[W-1:0];
    return x[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  // configuration and filter state
  logic [W-1:0] pn_r, mn_r, ie_r, ierr_r;
  logic [W-1:0] pn_nxt, mn_nxt, ie_nxt, ierr_nxt;
  logic [W-1:0] est_r, err_r, vel_r;

  // per-transaction working registers
  logic [W-1:0]   meas_r;
  logic [W:0]     pred_r, den_r;
  logic [W-1:0]   pe_r;
  logic           neg_r;
  logic [MW-1:0]  mag_r;
  logic [RW-1:0]  rem_r;
  logic [GW-1:0]  q_r, g1_r, g2_r;
  logic [PW1-1:0] acc1_r;
  logic [PW2-1:0] acc2_r;
  logic [W-1:0]   new_est_r, new_err_r;
  logic [W-1:0]   oest_r, oerr_r, ovel_r, onext_r;

  // prediction
  logic [W:0]   pred_nxt, pe_sum, den_nxt;
  logic [W-1:0] pe_nxt;
  logic [W+1:0] innov, innov_neg;

  always_comb begin
    pred_nxt  = {est_r[W-1], est_r} + {vel_r[W-1], vel_r};
    pe_sum    = {1'b0, err_r} + {1'b0, pn_r};
    pe_nxt    = pe_sum[W] ? '1 : pe_sum[W-1:0];
    den_nxt   = {1'b0, pe_nxt} + {1'b0, mn_r};
    innov     = {{2{meas_r[W-1]}}, meas_r} - {pred_nxt[W], pred_nxt};
    innov_neg = -innov;
  end

  // divider step
  logic [RW-1:0] den_ext, rem_diff, rem_nxt;
  logic          q_bit;

  always_comb begin
    den_ext  = {1'b0, den_r};
    q_bit    = rem_r >= den_ext;
    rem_diff = rem_r - den_ext;
    rem_nxt  = q_bit ? {rem_diff[RW-2:0], 1'b0} : {rem_r[RW-2:0], 1'b0};
  end

  // gain (zero for a zero denominator)
  logic [GW-1:0] gain;
  assign gain = (den_r == '0) ? '0 : q_r;

  // correction
  logic [W+1:0] prod1;
  logic [W+2:0] corr, est_sum;
  logic [W:0]   prod2;

  always_comb begin
    prod1   = acc1_r[PW1-1:F];
    corr    = neg_r ? -{1'b0, prod1} : {1'b0, prod1};
    est_sum = {{2{pred_r[W]}}, pred_r} + corr;
    prod2   = acc2_r[PW2-1:F];
  end

  // velocity and one-step prediction
  logic [W-1:0] vel_nxt, next_nxt;

  always_comb begin
    vel_nxt  = sat1({new_est_r[W-1], new_est_r} - {est_r[W-1], est_r});
    next_nxt = sat1({new_est_r[W-1], new_est_r} + {vel_nxt[W-1], vel_nxt});
  end

  // config write decode
  always_comb begin
    pn_nxt   = pn_r;
    mn_nxt   = mn_r;
    ie_nxt   = ie_r;
    ierr_nxt = ierr_r;
    case (cfg_idx_t'(cfg_index))
      CFG_PROC_NOISE:    pn_nxt   = cfg_data;
      CFG_MEAS_NOISE:    mn_nxt   = cfg_data;
      CFG_INIT_EST:      ie_nxt   = cfg_data;
      CFG_INIT_ERR:      ierr_nxt = cfg_data;
      default: begin
        pn_nxt = pn_r;
      end
    endcase
  end

  // config and state; any config write reloads the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r   <= ONE_W;
      mn_r   <= ONE_W;
      ie_r   <= '0;
      ierr_r <= ONE_W;
      est_r  <= '0;
      err_r  <= ONE_W;
      vel_r  <= '0;
    end else if (cfg_we) begin
      pn_r   <= pn_nxt;
      mn_r   <= mn_nxt;
      ie_r   <= ie_nxt;
      ierr_r <= ierr_nxt;
      est_r  <= ie_nxt;
      err_r  <= ierr_nxt;
      vel_r  <= '0;
    end else if (cmd.commit) begin
      est_r <= new_est_r;
      err_r <= new_err_r;
      vel_r <= vel_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) meas_r <= in_measurement;
    if (cmd.pred) begin
      pred_r <= pred_nxt;
      pe_r   <= pe_nxt;
      den_r  <= den_nxt;
      neg_r  <= innov[W+1];
      mag_r  <= innov[W+1] ? innov_neg[W:0] : innov[W:0];
      rem_r  <= {2'b00, pe_nxt};
      q_r    <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[GW-2:0], q_bit};
    end
    if (cmd.mul_init) begin
      g1_r   <= gain;
      g2_r   <= ONE_G - gain;
      acc1_r <= '0;
      acc2_r <= '0;
    end
    if (cmd.mul_step) begin
      acc1_r <= {acc1_r[PW1-2:0], 1'b0} + (g1_r[GW-1] ? {{GW{1'b0}}, mag_r} : '0);
      acc2_r <= {acc2_r[PW2-2:0], 1'b0} + (g2_r[GW-1] ? {{GW{1'b0}}, pe_r} : '0);
      g1_r   <= {g1_r[GW-2:0], 1'b0};
      g2_r   <= {g2_r[GW-2:0], 1'b0};
    end
    if (cmd.corr) begin
      new_est_r <= sat3(est_sum);
      new_err_r <= prod2[W] ? '1 : prod2[W-1:0];
    end
    if (cmd.commit) begin
      oest_r  <= new_est_r;
      oerr_r  <= new_err_r;
      ovel_r  <= vel_nxt;
      onext_r <= next_nxt;
    end
  end

  assign out_filtered_estimate = oest_r;
  assign out_error_variance    = oerr_r;
  assign out_rate_of_change    = ovel_r;
  assign out_next_prediction   = onext_r;

endmodule

// ----- bench/skvf_bench_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the scalar Kalman velocity filter bench: the bit-exact filter
// predictor and the in-order result check. Depends on skvf_pkg for register indexes.
package skvf_bench_pkg;
  import skvf_pkg::*;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam longint WORD_MAX_S = (64'sd1 <<< (WORD_W - 1)) - 1;
  localparam longint WORD_MIN_S = -WORD_MAX_S - 1;
  localparam bit [63:0] WORD_MAX_U = (64'd1 << WORD_W) - 1;
  localparam bit [63:0] ONE_FX = 64'd1 << FRAC_W;
  localparam int REPORT_LIMIT = 10;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t estimate;
    word_t variance;
    word_t rate;
    word_t ahead;
  } filter_result_t;

  class kalman_scoreboard;
    word_t drift_var;
    word_t meas_noise;
    word_t init_est;
    word_t init_err;
    longint est_now;
    longint vel_now;
    bit [63:0] err_now;
    filter_result_t awaited[$];
    int mismatches;

    function new();
      drift_var = word_t'(ONE_FX);
      meas_noise = word_t'(ONE_FX);
      init_est = '0;
      init_err = word_t'(ONE_FX);
      mismatches = 0;
      restart();
    endfunction

    // state reload, as done by reset and by every register write
    function void restart();
      est_now = longint'($signed(init_est));
      err_now = 64'(init_err);
      vel_now = 0;
    endfunction

    function void write_register(cfg_idx_t idx, word_t value);
      case (idx)
        CFG_PROC_NOISE:    drift_var = value;
        CFG_MEAS_NOISE:    meas_noise = value;
        CFG_INIT_EST:      init_est = value;
        CFG_INIT_ERR:      init_err = value;
        default:           return;
      endcase
      restart();
    endfunction

    // floor(u * g / 2^FRAC_W) for g <= 1.0
    static function bit [63:0] scale_fraction(bit [63:0] u, bit [63:0] g);
      return g * (u >> FRAC_W) + ((g * (u & (ONE_FX - 1))) >> FRAC_W);
    endfunction

    static function longint clamp_word(longint v);
      if (v > WORD_MAX_S) return WORD_MAX_S;
      if (v < WORD_MIN_S) return WORD_MIN_S;
      return v;
    endfunction

    function void note_measurement(word_t meas);
      longint m, old_est, pred_est, innov, corr, new_est, vel;
      bit [63:0] pe, den, rem, gain, mag, new_err;
      filter_result_t r;
      m = longint'($signed(meas));
      old_est = est_now;
      pred_est = est_now + vel_now;
      pe = err_now + 64'(drift_var);
      if (pe > WORD_MAX_U) pe = WORD_MAX_U;
      den = pe + 64'(meas_noise);
      // restoring division, one quotient bit per step; zero denominator leaves gain 0
      gain = '0;
      if (den != 0) begin
        rem = pe;
        if (rem >= den) begin
          rem = rem - den;
          gain = 64'd1;
        end
        for (int i = 0; i < FRAC_W; i++) begin
          rem = rem << 1;
          gain = gain << 1;
          if (rem >= den) begin
            rem = rem - den;
            gain = gain | 64'd1;
          end
        end
      end
      // correction magnitude truncates toward zero
      innov = m - pred_est;
      mag = (innov < 0) ? -innov : innov;
      mag = scale_fraction(mag, gain);
      corr = longint'(mag);
      if (innov < 0) corr = -corr;
      new_est = clamp_word(pred_est + corr);
      new_err = scale_fraction(pe, ONE_FX - gain);
      if (new_err > WORD_MAX_U) new_err = WORD_MAX_U;
      vel = clamp_word(new_est - old_est);
      est_now = new_est;
      err_now = new_err;
      vel_now = vel;
      r.estimate = word_t'(new_est);
      r.variance = word_t'(new_err);
      r.rate = word_t'(vel);
      r.ahead = word_t'(clamp_word(new_est + vel));
      awaited.push_back(r);
    endfunction

    function void compare_field(string label, word_t want, word_t seen);
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, seen);
      end
    endfunction

    function void check_result(filter_result_t seen);
      filter_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with none pending: est %h var %h rate %h next %h",
                   $time, seen.estimate, seen.variance, seen.rate, seen.ahead);
        return;
      end
      want = awaited.pop_front();
      compare_field("filtered_estimate", want.estimate, seen.estimate);
      compare_field("error_variance", want.variance, seen.variance);
      compare_field("rate_of_change", want.rate, seen.rate);
      compare_field("next_prediction", want.ahead, seen.ahead);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the scalar Kalman velocity filter bench: clock, reset, drivers, run control.
// Depends on skvf_pkg, skvf_bench_pkg and scalar_kalman_velocity_filter_unit.
module tb_top;
  import skvf_pkg::*;
  import skvf_bench_pkg::*;

  localparam int IDLE_PCT = 38;       // chance per cycle that a side idles
  localparam int RANDOM_PHASES = 12;
  localparam int SETTLE_CYCLES = 48;  // a bit over one transaction
  localparam int HOLD_CYCLES = 400;   // long result back-pressure stretch
  localparam word_t FX_ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_PROC_NOISE;
  word_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [WORD_W-1:0] in_measurement = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WORD_W-1:0] out_filtered_estimate;
  word_t out_error_variance;
  logic signed [WORD_W-1:0] out_rate_of_change;
  logic signed [WORD_W-1:0] out_next_prediction;

  // knobs shared between the stimulus and the result sink
  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int sink_hold = 0;

  // slowly moving target that the filter is meant to track
  logic signed [WORD_W-1:0] trend_pos = '0;
  logic signed [WORD_W-1:0] trend_step = '0;

  kalman_scoreboard sb = new;

  scalar_kalman_velocity_filter_unit #(
    .DATA_WIDTH(WORD_W),
    .FRAC_BITS (FRAC_W)
  ) DUT (.*);

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // Result monitor. Values read right at the edge are the pre-edge ones,
  // so this sees exactly what the DUT sees for the handshake.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_filtered_estimate, out_error_variance,
                        out_rate_of_change, out_next_prediction});
  end

  // Result sink: random stalls, a stall-free mode, and a long hold-off that
  // is counted here so the sender keeps pushing while the input backs up.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (sink_hold != 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (sink_stalls) begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // One measurement transaction. Valid stays up across back-to-back sends;
  // a gap only lowers it for whole cycles before the next item is offered.
  task automatic send_measurement(input logic signed [WORD_W-1:0] m);
    while (source_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measurement <= m;
    do @(posedge clk); while (!in_ready);
    sb.note_measurement(m);
  endtask

  // Stop offering and wait until every pending result has been taken.
  // Each measurement yields exactly one result, so an empty queue means idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_one(input cfg_idx_t idx, input word_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_register(idx, value);
  endtask

  // every write reloads estimate/error/velocity, so the last one decides the state
  task automatic write_registers(input word_t pn, input word_t mn,
                                 input word_t ie, input word_t ierr);
    drain();
    write_one(CFG_PROC_NOISE, pn);
    write_one(CFG_MEAS_NOISE, mn);
    write_one(CFG_INIT_EST, ie);
    write_one(CFG_INIT_ERR, ierr);
    cfg_we <= 1'b0;
  endtask

  function automatic word_t pick_extreme();
    case ($urandom_range(4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return FX_ONE;
    endcase
  endfunction

  // Mostly a noisy ramp (what a tracker normally sees), then full-range
  // noise, rail values and the odd jump of the target.
  function automatic logic signed [WORD_W-1:0] pick_measurement();
    int roll;
    roll = $urandom_range(99);
    trend_pos = trend_pos + trend_step;
    if (roll < 2) trend_pos = $urandom;
    if (roll < 70) return trend_pos + (int'($urandom_range(32767)) - 16384);
    if (roll < 90) return $urandom;
    case ($urandom_range(3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic configure_random(input int phase);
    word_t pn, mn, ie, ierr;
    case (phase % 3)
      0: begin
        // realistic tuning: noises up to a few units, estimate near zero
        pn = $urandom_range(32'h0004_0000);
        mn = $urandom_range(32'h0010_0000);
        ie = word_t'(int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
        ierr = $urandom_range(32'h0008_0000);
      end
      1: begin
        pn = $urandom;
        mn = $urandom;
        ie = $urandom;
        ierr = $urandom;
      end
      default: begin
        pn = pick_extreme();
        mn = pick_extreme();
        ie = pick_extreme();
        ierr = pick_extreme();
      end
    endcase
    write_registers(pn, mn, ie, ierr);
    trend_pos = ie;
    trend_step = (int'($urandom_range(4096)) - 2048) <<< 6;
  endtask

  initial begin : stimulus
    int n_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: rails, zero, one LSB either way, +/- 1.0
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh0000_0000);
    send_measurement(32'sh0000_0001);
    send_measurement(-32'sd1);
    send_measurement(32'sh0001_0000);
    send_measurement(32'shFFFF_0000);
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh8000_0000);

    // zero noise and zero error: denominator is 0, gain stays 0
    write_registers(32'h0, 32'h0, 32'h7FFF_0000, 32'h0);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh0000_0000);

    // no measurement noise: gain is exactly 1.0, velocity and prediction rail
    write_registers(FX_ONE, 32'h0, 32'h8000_0000, FX_ONE);
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh0000_0000);

    // predicted error overflows and saturates
    write_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7FFF_FFFF);
    send_measurement(32'sh0000_0000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure_random(p);
      n_items = $urandom_range(95, 120);
      if (p == 2) begin
        // stall-free stretch on both sides
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      if (p == 5) begin
        // sink holds off while the source keeps offering: input backs up
        source_gaps = 1'b0;
        sink_hold = HOLD_CYCLES;
      end
      for (int k = 0; k < n_items; k++) begin
        if (p == 7 && k == n_items / 2) drain();
        send_measurement(pick_measurement());
        if (p == 5 && k == 30) source_gaps = 1'b1;
      end
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
